@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clock outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

@@ rtl/core/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// Polyline densifier package
// Shared types and constants of the segment densifier.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int MAX_SLICES_DEF = 32;
   localparam int COORD_W        = 32;
   localparam int NUM_PARTS_W    = 6;
   localparam int SLICE_W        = 32;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [NUM_PARTS_W-1:0] NUM_PARTS_RST = NUM_PARTS_W'(20);
   localparam logic [SLICE_W-1:0]     SLICE_RST     = '0;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_PARTS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_SIZE = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pt_type;

   // One accepted vertex as work for the back end.
   typedef struct packed {
      pt_type prev;
      pt_type cur;
      pt_type start;
      logic   has_seg;     // segment prev -> cur
      logic   tail_point;  // open line end: emit cur alone
      logic   tail_ring;   // ring end: segment cur -> start
      logic   last;        // geometry ends with this job
   } job_type;

endpackage

@@ rtl/core/polyline_segment_densifier.sv @@
// ----------------------------------------------------------------------------
// Polyline segment densifier
// Splits each polyline segment into evenly spaced points by linear interpolation.
// ----------------------------------------------------------------------------
// A vertex request is taken by the front end and queued as a job unless it only
// opens a geometry; the back end then works through the job's one or two
// segments. Each segment has a setup step, then, when slice_size is nonzero, the
// squaring multiplier and the piece-count search (up to MAX_SLICES), then the
// shared-step restoring divider that splits the three deltas by the piece
// count, and then emits one point per cycle while the result side keeps taking
// them. The two-entry job queue lets new vertices be accepted while the back
// end is still emitting, so the front end stalls only when it is full.
// Configuration is written through the csr_ port and must only change while
// no request is in flight.
`include "assert_macros.svh"

module polyline_segment_densifier #(
   parameter int MAX_SLICES = psd_pkg::MAX_SLICES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [31:0]                     req_vx,
   input  logic signed [31:0]                     req_vy,
   input  logic signed [31:0]                     req_vz,
   input  logic                                   req_first_vertex,
   input  logic                                   req_last_vertex,
   input  logic                                   req_closed_ring,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [31:0]                     rsp_ox,
   output logic signed [31:0]                     rsp_oy,
   output logic signed [31:0]                     rsp_oz,
   output logic                                   rsp_run_end,
   output logic                                   rsp_geometry_end,
   input  logic                                   csr_we,
   input  logic [psd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [psd_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import psd_pkg::*;

   // Configuration registers.
   logic [NUM_PARTS_W-1:0] num_parts_ff, num_parts_in;
   logic [SLICE_W-1:0]     slice_size_ff, slice_size_in;

   // Job queue wiring between the front and back ends.
   logic    q_push, q_full, q_pop, q_valid;
   job_type q_job, q_head;

   always_comb begin
      num_parts_in  = num_parts_ff;
      slice_size_in = slice_size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_PARTS:  num_parts_in  = csr_wdata[NUM_PARTS_W-1:0];
            CSR_SLICE_SIZE: slice_size_in = csr_wdata[SLICE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff  <= NUM_PARTS_RST;
         slice_size_ff <= SLICE_RST;
      end else begin
         num_parts_ff  <= num_parts_in;
         slice_size_ff <= slice_size_in;
      end
   end

   // The front end classifies each vertex and keeps the previous and first vertex.
   psd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vx           (req_vx),
      .req_vy           (req_vy),
      .req_vz           (req_vz),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .req_closed_ring  (req_closed_ring),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (q_job)
   );

   psd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   // The back end sizes, divides and emits each segment of a job.
   psd_back #(
      .MAX_SLICES (MAX_SLICES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_valid),
      .head_job         (q_head),
      .pop              (q_pop),
      .num_parts        (num_parts_ff),
      .slice_size       (slice_size_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ox           (rsp_ox),
      .rsp_oy           (rsp_oy),
      .rsp_oz           (rsp_oz),
      .rsp_run_end      (rsp_run_end),
      .rsp_geometry_end (rsp_geometry_end)
   );

   // A geometry can only end on the last point of a request.
   `ASSERT_IMPL(a_geo_end_run_end, rsp_valid && rsp_geometry_end, rsp_run_end, "geo end alone")
   // The front end never pushes into a full queue.
   `ASSERT_NEVER(a_no_queue_overflow, q_push && q_full, "job pushed into full queue")

endmodule

@@ rtl/core/psd_front.sv @@
// ----------------------------------------------------------------------------
// Densifier front end
// Accepts vertices, tracks previous and first vertex, and issues jobs.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_vx,
   input  logic signed [31:0]            req_vy,
   input  logic signed [31:0]            req_vz,
   input  logic                          req_first_vertex,
   input  logic                          req_last_vertex,
   input  logic                          req_closed_ring,
   input  logic                          q_full,
   output logic                          q_push,
   output psd_pkg::job_type              q_job
);
   import psd_pkg::*;

   pt_type prev_ff, prev_in;
   pt_type start_ff, start_in;
   logic   have_prev_ff, have_prev_in;
   pt_type vtx;
   logic   first_eff;
   logic   accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign vtx       = '{x: req_vx, y: req_vy, z: req_vz};
   assign first_eff = req_first_vertex || !have_prev_ff;

   always_comb begin
      q_job.prev       = prev_ff;
      q_job.cur        = vtx;
      q_job.start      = first_eff ? vtx : start_ff;
      q_job.has_seg    = !first_eff;
      q_job.tail_point = req_last_vertex && !req_closed_ring;
      q_job.tail_ring  = req_last_vertex && req_closed_ring;
      q_job.last       = req_last_vertex;
      q_push           = accept && (!first_eff || req_last_vertex);
   end

   always_comb begin
      prev_in      = prev_ff;
      start_in     = start_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         prev_in      = vtx;
         start_in     = first_eff ? vtx : start_ff;
         have_prev_in = !req_last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         start_ff     <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

@@ rtl/core/psd_queue.sv @@
// ----------------------------------------------------------------------------
// Densifier job queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module psd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output psd_pkg::job_type head_job
);
   import psd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/psd_back.sv @@
// ----------------------------------------------------------------------------
// Densifier back end
// Sizes each segment, divides the deltas and emits interpolated points.
// ----------------------------------------------------------------------------
module psd_back #(
   parameter int MAX_SLICES = psd_pkg::MAX_SLICES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  psd_pkg::job_type     head_job,
   output logic                 pop,
   input  logic [5:0]           num_parts,
   input  logic [31:0]          slice_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_ox,
   output logic signed [31:0]   rsp_oy,
   output logic signed [31:0]   rsp_oz,
   output logic                 rsp_run_end,
   output logic                 rsp_geometry_end
);
   import psd_pkg::*;

   localparam int NW = $clog2(MAX_SLICES + 1);
   localparam int VW = 64 + 2 * NW;
   localparam int LW = 66;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SRCH  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]      state_ff, state_in;
   job_type         job_ff, job_in;
   logic            phase_ff, phase_in;
   logic            final_ff, final_in;
   pt_type          p0_ff, p0_in;
   logic [31:0]     mag_ff [3];
   logic [31:0]     mag_in [3];
   logic            neg_ff [3];
   logic            neg_in [3];
   logic [NW-1:0]   n_ff, n_in;
   logic [2:0]      mcnt_ff, mcnt_in;
   logic [63:0]     prod_ff, prod_in;
   logic [63:0]     s2_ff, s2_in;
   logic [LW-1:0]   len2_ff, len2_in;
   logic [NW-1:0]   k_ff, k_in;
   logic [VW-1:0]   v_ff, v_in;
   logic [VW-1:0]   t_ff, t_in;
   logic [4:0]      dcnt_ff, dcnt_in;
   logic [31:0]     dquo_ff [3];
   logic [31:0]     dquo_in [3];
   logic [NW-1:0]   drem_ff [3];
   logic [NW-1:0]   drem_in [3];
   logic [NW-1:0]   idx_ff, idx_in;
   logic [31:0]     q_ff [3];
   logic [31:0]     q_in [3];
   logic [NW-1:0]   r_ff [3];
   logic [NW-1:0]   r_in [3];
   logic            ov_ff, ov_in;
   pt_type          opt_ff, opt_in;
   logic            orun_ff, orun_in;
   logic            ogeo_ff, ogeo_in;

   pt_type          sp0, sp1;
   logic            out_free;
   logic [NW-1:0]   n_fixed;
   logic [6:0]      np_ext;
   logic [31:0]     mul_a;
   logic [VW-1:0]   v_next;
   logic [VW-1:0]   s2_ext;

   assign out_free         = !ov_ff || rsp_ready;
   assign rsp_valid        = ov_ff;
   assign rsp_ox           = opt_ff.x;
   assign rsp_oy           = opt_ff.y;
   assign rsp_oz           = opt_ff.z;
   assign rsp_run_end      = orun_ff;
   assign rsp_geometry_end = ogeo_ff;

   assign np_ext  = {1'b0, num_parts};
   assign n_fixed = (np_ext == '0) ? NW'(1) :
                    (np_ext > 7'(MAX_SLICES)) ? NW'(MAX_SLICES) : NW'(np_ext);
   assign s2_ext  = VW'(s2_ff);
   assign v_next  = v_ff + t_ff;

   always_comb begin
      case (mcnt_ff)
         3'd0:    mul_a = slice_size;
         3'd1:    mul_a = mag_ff[0];
         3'd2:    mul_a = mag_ff[1];
         default: mul_a = mag_ff[2];
      endcase
   end

   always_comb begin
      logic signed [32:0] diff;
      logic [NW:0]        rsh;
      logic [NW:0]        rsum;
      logic [31:0]        qv;
      logic [31:0]        pc [3];
      diff     = '0;
      rsh      = '0;
      rsum     = '0;
      qv       = '0;
      state_in = state_ff;
      job_in   = job_ff;
      phase_in = phase_ff;
      final_in = final_ff;
      p0_in    = p0_ff;
      n_in     = n_ff;
      mcnt_in  = mcnt_ff;
      prod_in  = prod_ff;
      s2_in    = s2_ff;
      len2_in  = len2_ff;
      k_in     = k_ff;
      v_in     = v_ff;
      t_in     = t_ff;
      dcnt_in  = dcnt_ff;
      idx_in   = idx_ff;
      ov_in    = ov_ff;
      opt_in   = opt_ff;
      orun_in  = orun_ff;
      ogeo_in  = ogeo_ff;
      pop      = 1'b0;
      for (int c = 0; c < 3; c++) begin
         pc[c]      = '0;
         mag_in[c]  = mag_ff[c];
         neg_in[c]  = neg_ff[c];
         dquo_in[c] = dquo_ff[c];
         drem_in[c] = drem_ff[c];
         q_in[c]    = q_ff[c];
         r_in[c]    = r_ff[c];
      end
      if (phase_ff) begin
         sp0 = job_ff.cur;
         sp1 = job_ff.start;
      end else begin
         sp0 = job_ff.prev;
         sp1 = job_ff.cur;
      end

      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               job_in   = head_job;
               phase_in = !head_job.has_seg;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            p0_in    = sp0;
            final_in = phase_ff || !(job_ff.tail_point || job_ff.tail_ring);
            for (int c = 0; c < 3; c++) begin
               case (c)
                  0:       diff = 33'(sp1.x) - 33'(sp0.x);
                  1:       diff = 33'(sp1.y) - 33'(sp0.y);
                  default: diff = 33'(sp1.z) - 33'(sp0.z);
               endcase
               neg_in[c]  = diff[32];
               mag_in[c]  = diff[32] ? 32'(-diff) : diff[31:0];
               dquo_in[c] = diff[32] ? 32'(-diff) : diff[31:0];
               drem_in[c] = '0;
               q_in[c]    = '0;
               r_in[c]    = '0;
            end
            dcnt_in = '0;
            idx_in  = '0;
            len2_in = '0;
            mcnt_in = '0;
            if (phase_ff && job_ff.tail_point) begin
               n_in     = NW'(1);
               state_in = ST_EMIT;
            end else if (slice_size == '0) begin
               n_in     = n_fixed;
               state_in = ST_DIV;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = 64'(mul_a) * 64'(mul_a);
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd1) begin
               s2_in = prod_ff;
            end else if (mcnt_ff != 3'd0) begin
               len2_in = len2_ff + LW'(prod_ff);
            end
            if (mcnt_ff == 3'd4) begin
               k_in     = NW'(1);
               v_in     = s2_ext;
               t_in     = s2_ext + (s2_ext << 1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if ((k_ff < NW'(MAX_SLICES)) && (v_next <= VW'(len2_ff))) begin
               k_in = k_ff + 1'b1;
               v_in = v_next;
               t_in = t_ff + (s2_ext << 1);
            end else begin
               n_in     = k_ff;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int c = 0; c < 3; c++) begin
               rsh = {drem_ff[c], dquo_ff[c][31]};
               if (rsh >= {1'b0, n_ff}) begin
                  rsh        = rsh - {1'b0, n_ff};
                  dquo_in[c] = {dquo_ff[c][30:0], 1'b1};
               end else begin
                  dquo_in[c] = {dquo_ff[c][30:0], 1'b0};
               end
               drem_in[c] = rsh[NW-1:0];
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'd31) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               for (int c = 0; c < 3; c++) begin
                  case (c)
                     0:       qv = p0_ff.x;
                     1:       qv = p0_ff.y;
                     default: qv = p0_ff.z;
                  endcase
                  pc[c] = neg_ff[c] ? qv - q_ff[c] : qv + q_ff[c];
                  rsum  = {1'b0, r_ff[c]} + {1'b0, drem_ff[c]};
                  if (rsum >= {1'b0, n_ff}) begin
                     r_in[c] = NW'(rsum - {1'b0, n_ff});
                     q_in[c] = q_ff[c] + dquo_ff[c] + 32'd1;
                  end else begin
                     r_in[c] = rsum[NW-1:0];
                     q_in[c] = q_ff[c] + dquo_ff[c];
                  end
               end
               ov_in   = 1'b1;
               opt_in  = '{x: pc[0], y: pc[1], z: pc[2]};
               orun_in = final_ff && (idx_ff == n_ff - 1'b1);
               ogeo_in = final_ff && (idx_ff == n_ff - 1'b1) && job_ff.last;
               idx_in  = idx_ff + 1'b1;
               if (idx_ff == n_ff - 1'b1) begin
                  if (!phase_ff && (job_ff.tail_point || job_ff.tail_ring)) begin
                     phase_in = 1'b1;
                     state_in = ST_SETUP;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      final_ff <= final_in;
      p0_ff    <= p0_in;
      n_ff     <= n_in;
      prod_ff  <= prod_in;
      s2_ff    <= s2_in;
      len2_ff  <= len2_in;
      k_ff     <= k_in;
      v_ff     <= v_in;
      t_ff     <= t_in;
      dcnt_ff  <= dcnt_in;
      idx_ff   <= idx_in;
      mcnt_ff  <= mcnt_in;
      opt_ff   <= opt_in;
      orun_ff  <= orun_in;
      ogeo_ff  <= ogeo_in;
      for (int c = 0; c < 3; c++) begin
         mag_ff[c]  <= mag_in[c];
         neg_ff[c]  <= neg_in[c];
         dquo_ff[c] <= dquo_in[c];
         drem_ff[c] <= drem_in[c];
         q_ff[c]    <= q_in[c];
         r_ff[c]    <= r_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Polyline segment densifier testbench
// Drives vertex requests through random and directed polylines and rings,
// predicts every densified point in a scoreboard and checks each response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   logic [31:0] x;
   logic [31:0] y;
   logic [31:0] z;
   bit          run_end;
   bit          geometry_end;
} dense_point_type;

// Holds its own copy of the vertex history and the registers, and keeps the
// points still owed by the block in arrival order.
class densify_scoreboard;
   dense_point_type owed[$];
   longint       last_pt[3];
   longint       ring_pt[3];
   bit           have_last;
   bit [5:0]     num_parts;
   bit [31:0]    slice_size;
   int           errors;

   function new();
      num_parts  = 6'd20;
      slice_size = '0;
   endfunction

   // Piece count of one segment: fixed, or the most pieces no shorter than
   // the slice size, clamped to 1..32.
   function int piece_count(longint a[3], longint b[3]);
      bit [127:0]      len2;
      bit [127:0]      ks;
      longint unsigned d;
      int n;
      len2 = '0;
      if (slice_size == 0) begin
         n = int'(num_parts);
         if (n < 1) n = 1;
         if (n > 32) n = 32;
         return n;
      end
      for (int c = 0; c < 3; c++) begin
         d = (b[c] >= a[c]) ? longint'(b[c] - a[c]) : longint'(a[c] - b[c]);
         len2 += 128'(d) * 128'(d);
      end
      for (int k = 32; k >= 2; k--) begin
         ks = 128'(k) * 128'(slice_size);
         if (ks * ks <= len2) return k;
      end
      return 1;
   endfunction

   function void push_point(longint p[3]);
      dense_point_type q;
      q.x = p[0][31:0];
      q.y = p[1][31:0];
      q.z = p[2][31:0];
      q.run_end = 0;
      q.geometry_end = 0;
      owed = {owed, q};
   endfunction

   function void push_segment(longint a[3], longint b[3]);
      longint p[3];
      int n;
      n = piece_count(a, b);
      push_point(a);
      for (int i = 1; i < n; i++) begin
         for (int c = 0; c < 3; c++) p[c] = a[c] + ((b[c] - a[c]) * i) / n;
         push_point(p);
      end
   endfunction

   // Called for every accepted vertex request.
   function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             bit first, bit last, bit ring);
      longint v[3];
      int     before_cnt;
      before_cnt = owed.size();
      v[0] = longint'($signed(vx));
      v[1] = longint'($signed(vy));
      v[2] = longint'($signed(vz));
      if (first || !have_last) ring_pt = v;
      else push_segment(last_pt, v);
      last_pt   = v;
      have_last = 1;
      if (last) begin
         if (ring) push_segment(v, ring_pt);
         else push_point(v);
         have_last = 0;
      end
      if (owed.size() > before_cnt) begin
         owed[$].run_end = 1;
         owed[$].geometry_end = last;
      end
   endfunction

   function void check_point(dense_point_type got);
      dense_point_type want;
      if (owed.size() == 0) begin
         $error("unexpected response point x=%h y=%h z=%h", got.x, got.y, got.z);
         errors++;
         return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) begin
         $error("ox expected %h actual %h", want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
         $error("oy expected %h actual %h", want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
         $error("oz expected %h actual %h", want.z, got.z); errors++;
      end
      if (got.run_end !== want.run_end) begin
         $error("run_end expected %b actual %b", want.run_end, got.run_end); errors++;
      end
      if (got.geometry_end !== want.geometry_end) begin
         $error("geometry_end expected %b actual %b", want.geometry_end,
                got.geometry_end);
         errors++;
      end
   endfunction
endclass

module testbench;
   import psd_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_vx = '0;
   logic [31:0] req_vy = '0;
   logic [31:0] req_vz = '0;
   logic        req_first_vertex = 0;
   logic        req_last_vertex = 0;
   logic        req_closed_ring = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_ox;
   logic [31:0] rsp_oy;
   logic [31:0] rsp_oz;
   logic        rsp_run_end;
   logic        rsp_geometry_end;
   logic                   csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   densify_scoreboard board = new();
   // When set, neither side inserts idle cycles.
   bit     no_idle = 0;
   longint cycles = 0;

   polyline_segment_densifier u_dut (.*);

   always #2 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: check every accepted point, then draw how long to hold
   // ready low before taking the next one.
   initial begin
      int hold;
      dense_point_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.x = rsp_ox;
            got.y = rsp_oy;
            got.z = rsp_oz;
            got.run_end = rsp_run_end;
            got.geometry_end = rsp_geometry_end;
            board.check_point(got);
            hold = no_idle ? 0 : $urandom_range(0, 5);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_ready <= (hold == 0) && !reset;
      end
   end

   // Sends one vertex request after a random gap and waits until it is taken.
   // Valid stays high into the next request when no gap is drawn.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit first, bit last, bit ring);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1;
      req_vx           <= x;
      req_vy           <= y;
      req_vz           <= z;
      req_first_vertex <= first;
      req_last_vertex  <= last;
      req_closed_ring  <= ring;
      do @(posedge clock); while (!req_ready);
      board.note_vertex(x, y, z, first, last, ring);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      // A lone first vertex owes no point and never reaches the back end.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers change only with the block idle.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      drain();
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_NUM_PARTS) board.num_parts = data[5:0];
      else board.slice_size = data;
   endtask

   function automatic logic [31:0] pick_coord(logic [31:0] near);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return near + 32'($signed($urandom_range(0, 32'h0100_0000))
                                    - 32'sh0080_0000);
      endcase
   endfunction

   // One random geometry; occasionally noise with arbitrary flags.
   task automatic send_geometry();
      int len;
      bit ring;
      logic [31:0] x, y, z;
      x = $urandom(); y = $urandom(); z = $urandom();
      if ($urandom_range(0, 9) == 0) begin
         send_vertex($urandom(), $urandom(), $urandom(), bit'($urandom_range(0, 1)),
                     bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
         return;
      end
      len  = $urandom_range(1, 5);
      ring = bit'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         x = pick_coord(x); y = pick_coord(y); z = pick_coord(z);
         // The ring flag only matters on the last vertex; toggle it elsewhere.
         send_vertex(x, y, z, i == 0, i == len - 1,
                     (i == len - 1) ? ring : bit'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part under reset settings: 20 pieces per segment.
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1, 1'b1, 1'b0);
      send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b0, 1'b1);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b0, 1'b1, 1'b1);
      // Vertices with no first flag right after a geometry ended.
      send_vertex(32'h0012_3456, 32'hfedc_ba98, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
      send_vertex(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1, 1'b0);
      // A first vertex in mid-geometry restarts it.
      send_vertex(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h0000_5000, 32'h0000_6000, 32'h0000_7000, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h0000_9000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1);

      write_csr(CSR_NUM_PARTS, 32'd1);
      send_vertex(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 1'b0, 1'b1, 1'b1);
      write_csr(CSR_NUM_PARTS, 32'd0);
      send_vertex(32'h0100_0000, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h0200_0000, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0);
      write_csr(CSR_NUM_PARTS, 32'd63);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b1, 1'b1);

      // Random part: each phase a different register setting.
      sent = 0;
      for (int phase = 0; sent < 450; phase++) begin
         case (phase % 8)
            0: write_csr(CSR_NUM_PARTS, 32'd32);
            1: write_csr(CSR_NUM_PARTS, $urandom_range(0, 63));
            2: write_csr(CSR_SLICE_SIZE, 32'd1);
            3: write_csr(CSR_SLICE_SIZE, 32'hffff_ffff);
            4: write_csr(CSR_SLICE_SIZE, $urandom_range(32'h0010_0000, 32'h4000_0000));
            5: write_csr(CSR_SLICE_SIZE, $urandom_range(32'h0000_1000, 32'h0010_0000));
            6: write_csr(CSR_SLICE_SIZE, $urandom());
            default: write_csr(CSR_SLICE_SIZE, 32'd0);
         endcase
         no_idle = (phase % 3 == 2);
         for (int g = 0; g < 12; g++) begin
            send_geometry();
            sent += 3;
         end
      end

      drain();
      if (board.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

@@ polyline_segment_densifier.f @@
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_front.sv
rtl/core/psd_queue.sv
rtl/core/psd_back.sv
rtl/core/polyline_segment_densifier.sv
sim/testbench.sv
